@@ sv/line_offset_nearest_point_defines.svh @@
// assertion macros shared by the line offset nearest point rtl
`ifndef LINE_OFFSET_NEAREST_POINT_DEFINES_SVH
`define LINE_OFFSET_NEAREST_POINT_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define LONP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next clock
`define LONP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/lonp_pkg.sv @@
// shared types, widths and codes of the line offset nearest point block
package lonp_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 24;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int OFF_W      = 23;
  localparam int DIFF_W     = 27;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int SQV_W      = 52;
  localparam int ROOT_W     = SQV_W / 2;
  localparam int SQREM_W    = ROOT_W + 2;
  localparam int LEN_W      = 26;
  localparam int DVD_W      = 49;
  localparam int QUO_W      = 25;
  localparam int TGT_W      = 26;
  localparam int BIT_W      = 6;
  localparam int AX_W       = 2;

  localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(9175);

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_OFF   = 2'd2;

  typedef enum logic [1:0] {
    RD_START = 2'd0,
    RD_END   = 2'd1,
    RD_IDX   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic             nearest_found;
    logic [IDX_W-1:0] half_nearest_index;
    logic             half_found;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic             chk;
    logic             lat_s;
    logic             lat_e;
    logic             sq_mul;
    logic             sq_acc;
    logic             sqrt_ld;
    logic             sqrt_step;
    logic             sqrt_rnd;
    logic             sc_mul;
    logic             sc_ld;
    logic             div_step;
    logic             sc_tgt;
    logic             th_mul;
    logic             th_ld;
    logic             pt_ld;
    logic             pt_cmp;
    logic             emit;
    logic             rd_en;
    rd_sel_t          rd_sel;
    logic [AX_W-1:0]  axis;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic d_zero;
    logic idx_last;
  } sts_t;

endpackage

@@ sv/line_offset_nearest_point.sv @@
// top level: configuration registers, controller and datapath
// Points are transferred one per cycle while busy is low; the store holds 1024 points and
// further points are dropped. The transfer whose last_point bit is set starts the search and
// raises busy. Busy then stays high through the line setup and the sweep over the cloud.
// The setup covers the start and end reads, the squared line length, a 26-step square
// root with load and rounding, three scale divisions of 49 steps each, and the threshold.
// Each stored point then takes one store read, one load, and three squares through the
// single shared multiplier, followed by the compare. After busy falls, the controller's
// done flag is registered into out_valid. A range error result is found in the check
// state and a zero-length line result in the end read, with no sweep. The result appears
// on out_data for one cycle with out_valid high and cannot be held off by the receiver.
module line_offset_nearest_point import lonp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [IDX_W-1:0] start_idx_r, end_idx_r;
  logic [OFF_W-1:0] offset_r;
  logic             in_accept, cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_idx_r <= '0;
      end_idx_r   <= '0;
      offset_r    <= OFF_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START: start_idx_r <= pwdata[IDX_W-1:0];
        REG_END:   end_idx_r   <= pwdata[IDX_W-1:0];
        REG_OFF:   offset_r    <= pwdata[OFF_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START: prdata = 32'(start_idx_r);
      REG_END:   prdata = 32'(end_idx_r);
      REG_OFF:   prdata = 32'(offset_r);
      default:   prdata = '0;
    endcase
  end

  lonp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_last   (in_data.last_point),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  lonp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_data         (in_data),
    .start_index     (start_idx_r),
    .end_index       (end_idx_r),
    .offset_distance (offset_r),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_data        (out_data)
  );

endmodule

@@ sv/lonp_dp.sv @@
// datapath: point store, shared multiplier, square root, divider and search compare
module lonp_dp import lonp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  in_item_t         in_data,
  input  logic [IDX_W-1:0] start_index,
  input  logic [IDX_W-1:0] end_index,
  input  logic [OFF_W-1:0] offset_distance,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  output out_item_t        out_data
);

  logic [3*COORD_W-1:0] mem [MAX_POINTS];
  logic [3*COORD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;

  logic [CNT_W-1:0] cnt_r, n_r;
  logic             full;

  logic signed [COORD_W-1:0] s_r  [3];
  logic signed [DIFF_W-1:0]  dv_r [3];
  logic signed [TGT_W-1:0]   t_r  [3];
  logic signed [COORD_W-1:0] rd_pt [3];

  logic [DIFF_W-1:0]  op_a, op_b, dv_mag;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   acc_r, best_r, hbest_r;

  logic [SQV_W-1:0]   sq_v_r;
  logic [SQREM_W-1:0] sq_rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [SQREM_W+1:0] sq_trial, sq_test;
  logic [LEN_W-1:0]   len_r;

  logic [DVD_W-1:0]   dvd_r;
  logic [LEN_W-1:0]   drem_r;
  logic [LEN_W:0]     div_trial;
  logic [QUO_W-1:0]   quo;

  logic [IDX_W-1:0]   bidx_r, hidx_r;
  logic               found_r, hfound_r;
  logic [1:0]         status_r;
  logic [CNT_W-1:0]   half;
  logic               in_half;

  logic               out_valid_r;
  out_item_t          out_r;

  assign full = (cnt_r >= CNT_W'(MAX_POINTS));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_START: rd_addr = start_index;
      RD_END:   rd_addr = end_index;
      default:  rd_addr = cmd.idx;
    endcase
  end

  // point store, one write port for loading and one registered read port
  always_ff @(posedge clk) begin
    if (in_accept && !full) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_data.coord_z, in_data.coord_y, in_data.coord_x};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_pt[0] = rd_data_r[COORD_W-1:0];
  assign rd_pt[1] = rd_data_r[2*COORD_W-1:COORD_W];
  assign rd_pt[2] = rd_data_r[3*COORD_W-1:2*COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= '0;
    end else if (in_accept) begin
      if (in_data.last_point) begin
        n_r   <= full ? cnt_r : cnt_r + CNT_W'(1);
        cnt_r <= '0;
      end else if (!full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign sts.range_bad = ({1'b0, start_index} >= n_r) || ({1'b0, end_index} >= n_r);
  assign sts.d_zero    = (rd_pt[0] == s_r[0]) && (rd_pt[1] == s_r[1]) && (rd_pt[2] == s_r[2]);
  assign sts.idx_last  = (({1'b0, cmd.idx} + CNT_W'(1)) == n_r);

  assign half    = CNT_W'((n_r + CNT_W'(1)) >> 1);
  assign in_half = ({1'b0, cmd.idx} < half);

  // coordinate and difference registers
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.lat_s) begin
        s_r[a] <= rd_pt[a];
      end
      if (cmd.lat_e) begin
        dv_r[a] <= DIFF_W'(rd_pt[a]) - DIFF_W'(s_r[a]);
      end else if (cmd.pt_ld) begin
        dv_r[a] <= DIFF_W'(rd_pt[a]) - DIFF_W'(t_r[a]);
      end
    end
    if (cmd.sc_tgt) begin
      t_r[cmd.axis] <= dv_r[cmd.axis][DIFF_W-1] ?
                       TGT_W'(s_r[cmd.axis]) - TGT_W'({1'b0, quo}) :
                       TGT_W'(s_r[cmd.axis]) + TGT_W'({1'b0, quo});
    end
  end

  // shared multiplier, product registered
  assign dv_mag = dv_r[cmd.axis][DIFF_W-1] ? DIFF_W'(-dv_r[cmd.axis]) : DIFF_W'(dv_r[cmd.axis]);

  always_comb begin
    op_a = dv_mag;
    op_b = dv_mag;
    if (cmd.sc_mul) begin
      op_b = DIFF_W'(offset_distance);
    end else if (cmd.th_mul) begin
      op_a = DIFF_W'(offset_distance);
      op_b = DIFF_W'(offset_distance);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_mul || cmd.sc_mul || cmd.th_mul) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.lat_e || cmd.pt_ld) begin
      acc_r <= '0;
    end else if (cmd.sq_acc) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // square root, one result bit per cycle
  assign sq_trial = {sq_rem_r, sq_v_r[SQV_W-1 -: 2]};
  assign sq_test  = (SQREM_W+2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_ld) begin
      sq_v_r   <= acc_r[SQV_W-1:0];
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_v_r <= {sq_v_r[SQV_W-3:0], 2'b00};
      if (sq_trial >= sq_test) begin
        sq_rem_r <= SQREM_W'(sq_trial - sq_test);
        root_r   <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r <= SQREM_W'(sq_trial);
        root_r   <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    // round to nearest: r*(r+1) < v is rem > r
    if (cmd.sqrt_rnd) begin
      len_r <= (sq_rem_r > SQREM_W'(root_r)) ? LEN_W'(root_r) + LEN_W'(1) : LEN_W'(root_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_trial = {drem_r, dvd_r[DVD_W-1]};
  assign quo       = dvd_r[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sc_ld) begin
      dvd_r  <= DVD_W'(prod_r) + DVD_W'(len_r >> 1);
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (div_trial >= {1'b0, len_r}) begin
        drem_r <= LEN_W'(div_trial - {1'b0, len_r});
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        drem_r <= LEN_W'(div_trial);
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // running best of the whole cloud and of its first half
  always_ff @(posedge clk) begin
    if (cmd.th_ld) begin
      best_r  <= ACC_W'(prod_r);
      hbest_r <= ACC_W'(prod_r);
    end else if (cmd.pt_cmp) begin
      if (acc_r < best_r) begin
        best_r <= acc_r;
      end
      if (in_half && (acc_r < hbest_r)) begin
        hbest_r <= acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      hfound_r <= 1'b0;
      bidx_r   <= '0;
      hidx_r   <= '0;
      status_r <= STAT_OK;
    end else if (cmd.chk) begin
      found_r  <= 1'b0;
      hfound_r <= 1'b0;
      bidx_r   <= '0;
      hidx_r   <= '0;
      status_r <= sts.range_bad ? STAT_RANGE : STAT_OK;
    end else if (cmd.lat_e && sts.d_zero) begin
      status_r <= STAT_ZERO;
    end else if (cmd.pt_cmp) begin
      if (acc_r < best_r) begin
        found_r <= 1'b1;
        bidx_r  <= cmd.idx;
      end
      if (in_half && (acc_r < hbest_r)) begin
        hfound_r <= 1'b1;
        hidx_r   <= cmd.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_r.nearest_index      <= bidx_r;
      out_r.nearest_found      <= found_r;
      out_r.half_nearest_index <= hidx_r;
      out_r.half_found         <= hfound_r;
      out_r.status             <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/lonp_ctrl.sv @@
// controller: sequences the line setup and the sweep over the stored cloud
`include "line_offset_nearest_point_defines.svh"

module lonp_ctrl import lonp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_accept,
  input  logic in_last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_CHK   = 18'b000000000000000010,
    S_RDS   = 18'b000000000000000100,
    S_RDE   = 18'b000000000000001000,
    S_SQM   = 18'b000000000000010000,
    S_SQA   = 18'b000000000000100000,
    S_SQL   = 18'b000000000001000000,
    S_SQRT  = 18'b000000000010000000,
    S_SQRND = 18'b000000000100000000,
    S_SCM   = 18'b000000001000000000,
    S_SCL   = 18'b000000010000000000,
    S_DIV   = 18'b000000100000000000,
    S_SCT   = 18'b000001000000000000,
    S_THM   = 18'b000010000000000000,
    S_THL   = 18'b000100000000000000,
    S_SRD   = 18'b001000000000000000,
    S_SLD   = 18'b010000000000000000,
    S_SCMP  = 18'b100000000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AX_W-1:0]  axis_r, axis_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BIT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic             ctx_r, ctx_nxt;
  logic             done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      axis_r    <= '0;
      idx_r     <= '0;
      bit_cnt_r <= '0;
      ctx_r     <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      axis_r    <= axis_nxt;
      idx_r     <= idx_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      ctx_r     <= ctx_nxt;
      done_r    <= done_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    idx_nxt     = idx_r;
    bit_cnt_nxt = bit_cnt_r;
    ctx_nxt     = ctx_r;
    done_nxt    = 1'b0;
    cmd         = '0;
    cmd.rd_sel  = RD_IDX;
    cmd.axis    = axis_r;
    cmd.idx     = idx_r;
    cmd.emit    = done_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_last) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_START;
        if (sts.range_bad) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RDS;
        end
      end
      S_RDS: begin
        cmd.lat_s  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_END;
        state_nxt  = S_RDE;
      end
      S_RDE: begin
        cmd.lat_e = 1'b1;
        axis_nxt  = '0;
        ctx_nxt   = 1'b0;
        if (sts.d_zero) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SQM;
        end
      end
      S_SQM: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = S_SQA;
      end
      S_SQA: begin
        cmd.sq_acc = 1'b1;
        if (axis_r == AX_W'(2)) begin
          axis_nxt  = '0;
          state_nxt = ctx_r ? S_SCMP : S_SQL;
        end else begin
          axis_nxt  = axis_r + AX_W'(1);
          state_nxt = S_SQM;
        end
      end
      S_SQL: begin
        cmd.sqrt_ld = 1'b1;
        bit_cnt_nxt = BIT_W'(ROOT_W - 1);
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = S_SQRND;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
        end
      end
      S_SQRND: begin
        cmd.sqrt_rnd = 1'b1;
        axis_nxt     = '0;
        state_nxt    = S_SCM;
      end
      S_SCM: begin
        cmd.sc_mul = 1'b1;
        state_nxt  = S_SCL;
      end
      S_SCL: begin
        cmd.sc_ld   = 1'b1;
        bit_cnt_nxt = BIT_W'(DVD_W - 1);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = S_SCT;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
        end
      end
      S_SCT: begin
        cmd.sc_tgt = 1'b1;
        if (axis_r == AX_W'(2)) begin
          axis_nxt  = '0;
          state_nxt = S_THM;
        end else begin
          axis_nxt  = axis_r + AX_W'(1);
          state_nxt = S_SCM;
        end
      end
      S_THM: begin
        cmd.th_mul = 1'b1;
        state_nxt  = S_THL;
      end
      S_THL: begin
        cmd.th_ld = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SLD;
      end
      S_SLD: begin
        cmd.pt_ld = 1'b1;
        axis_nxt  = '0;
        ctx_nxt   = 1'b1;
        state_nxt = S_SQM;
      end
      S_SCMP: begin
        cmd.pt_cmp = 1'b1;
        if (sts.idx_last) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `LONP_ASSERT_NEXT(a_last_starts_check, in_accept && in_last, state_r == S_CHK, "last point did not start the search")
  `LONP_ASSERT_NEXT(a_done_one_cycle, done_r, !done_r, "result strobe held for more than one cycle")
  `LONP_ASSERT_NEXT(a_div_count, state_r == S_DIV && bit_cnt_r != '0, state_r == S_DIV && bit_cnt_r == $past(bit_cnt_r) - BIT_W'(1), "divider left early or skipped a bit")
  `LONP_ASSERT(a_no_accept_busy, busy |-> !in_accept, "item transferred while busy")

endmodule
